// ===== src/sacta_pkg.sv =====
// ----------------------------------------------------------------------------
// sacta_pkg
// shared types, constants and codes of the set-associative cache tag array
// ----------------------------------------------------------------------------
package sacta_pkg;

	localparam int SETS_DEF      = 64;
	localparam int WAYS_DEF      = 4;
	localparam int ADDR_BITS_DEF = 64;

	localparam int IDX_MAX = 6;
	localparam int OFS_MAX = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INDEX_WIDTH  = 2'd0,
		CFG_OFFSET_WIDTH = 2'd1,
		CFG_REPLACE_MODE = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_FILL  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] address;
	} in_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way_used;
		logic        replaced_valid;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] access_count;
		logic [31:0] fill_count;
	} out_t;

	typedef struct packed {
		logic [2:0] index_width;
		logic [3:0] offset_width;
		logic       replace_mode;
	} cfg_t;

endpackage

// ===== src/set_assoc_cache_tag_array_core.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_core
// set-associative tag array with true lru or round-robin fill and counters
// ----------------------------------------------------------------------------
// path: input beat -> set row read (stage 1) -> update into the result beat
// throughput: one beat per cycle when out_stall is low; set rows sit in ram, a
//   same-set follow-up beat takes the just-written row from a bypass register
// reset: counters and per-set touched bits clear at once, so no clearing pass;
//   an untouched set reads as all ways invalid, ages by way number, pointer zero
module set_assoc_cache_tag_array_core import sacta_pkg::*; #(
	parameter int SETS      = SETS_DEF,
	parameter int WAYS      = WAYS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data
);

	localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAGS_W = WAYS * ADDR_BITS;
	localparam int META_W = WAYS + WAYS * WW + WW;

	typedef logic [WAYS-1:0][ADDR_BITS-1:0] tag_row_t;
	typedef struct packed {
		logic [WAYS-1:0]          vld;
		logic [WW-1:0]            rr;
		logic [WAYS-1:0][WW-1:0]  ages;
	} meta_t;

	cfg_t                   cfg_q;
	logic                   in_acc;
	logic                   adv;
	logic [SW-1:0]          set_in;
	logic [ADDR_BITS-1:0]   tag_in;

	logic                   valid_s1;
	logic [1:0]             op_s1;
	logic [SW-1:0]          set_s1;
	logic [ADDR_BITS-1:0]   tag_s1;
	logic                   byp_s1;
	tag_row_t               byp_tags_q;
	meta_t                  byp_meta_q;

	logic [SETS-1:0]        touched_q;
	logic [31:0]            hits_q, misses_q, reads_q, fills_q;

	logic [TAGS_W-1:0]      tags_rd;
	logic [META_W-1:0]      meta_rd;
	meta_t                  meta_rst;
	tag_row_t               cur_tags;
	meta_t                  cur_meta;
	tag_row_t               new_tags;
	meta_t                  new_meta;
	logic [WAYS-1:0]        cur_vld;

	logic                   is_read, is_fill, is_clear;
	logic                   hit;
	logic [WW-1:0]          hit_way;
	logic                   inv_found;
	logic [WW-1:0]          inv_way;
	logic [WW-1:0]          lru_way;
	logic [WW-1:0]          lru_age;
	logic [WW-1:0]          fill_way;
	logic [WW-1:0]          sel_way;
	logic [WW-1:0]          old_age;
	logic [WW+1:0]          way_x;
	logic                   wr;
	logic [31:0]            hits_d, misses_d, reads_d, fills_d;
	out_t                   res;

	// ------------------------------------------------------------ config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_width  <= 3'd6;
			cfg_q.offset_width <= 4'd6;
			cfg_q.replace_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_INDEX_WIDTH:  cfg_q.index_width  <= cfg_data[2:0];
				CFG_OFFSET_WIDTH: cfg_q.offset_width <= cfg_data;
				CFG_REPLACE_MODE: cfg_q.replace_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ handshake
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	sacta_addr_split #(
		.SETS      (SETS),
		.ADDR_BITS (ADDR_BITS)
	) u_split (
		.address (in_data.address),
		.cfg     (cfg_q),
		.set_num (set_in),
		.tag     (tag_in)
	);

	sacta_ram #(.WIDTH(TAGS_W), .DEPTH(SETS)) u_tag_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (set_s1),
		.wdata (new_tags),
		.re    (in_acc),
		.raddr (set_in),
		.rdata (tags_rd)
	);

	sacta_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (set_s1),
		.wdata (new_meta),
		.re    (in_acc),
		.raddr (set_in),
		.rdata (meta_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				byp_s1   <= wr && (set_in == set_s1);
			end else if (adv) begin
				valid_s1 <= 1'b0;
				byp_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1  <= in_data.opcode;
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
		if (wr) begin
			byp_tags_q <= new_tags;
			byp_meta_q <= new_meta;
		end
	end

	// reset image of a set's replacement state
	always_comb begin
		meta_rst.vld = '0;
		meta_rst.rr  = '0;
		for (int w = 0; w < WAYS; w++) begin
			meta_rst.ages[w] = WW'(w);
		end
	end

	// ------------------------------------------------------------ lookup and update
	always_comb begin
		cur_tags = byp_s1 ? byp_tags_q : tag_row_t'(tags_rd);
		cur_meta = byp_s1 ? byp_meta_q : (touched_q[set_s1] ? meta_t'(meta_rd) : meta_rst);
		cur_vld  = cur_meta.vld;

		is_read  = (op_s1 == OP_READ);
		is_fill  = (op_s1 == OP_FILL);
		is_clear = (op_s1 == OP_CLEAR);

		hit       = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		lru_way   = '0;
		lru_age   = cur_meta.ages[0];
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && cur_vld[w] && (cur_tags[w] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WW'(w);
			end
			if (!inv_found && !cur_vld[w]) begin
				inv_found = 1'b1;
				inv_way   = WW'(w);
			end
			// first way holding the largest age
			if (cur_meta.ages[w] > lru_age) begin
				lru_age = cur_meta.ages[w];
				lru_way = WW'(w);
			end
		end
		hit = hit && is_read;

		if (inv_found) begin
			fill_way = inv_way;
		end else if (cfg_q.replace_mode) begin
			fill_way = cur_meta.rr;
		end else begin
			fill_way = lru_way;
		end
		sel_way = is_read ? hit_way : fill_way;

		old_age  = cur_meta.ages[sel_way];
		new_meta = cur_meta;
		for (int w = 0; w < WAYS; w++) begin
			if (WW'(w) == sel_way) begin
				new_meta.ages[w] = '0;
			end else if (cur_meta.ages[w] < old_age) begin
				new_meta.ages[w] = cur_meta.ages[w] + WW'(1);
			end
		end
		if (is_fill) begin
			new_meta.vld[sel_way] = 1'b1;
		end
		if (is_fill && !inv_found && cfg_q.replace_mode) begin
			new_meta.rr = (fill_way == WW'(WAYS - 1)) ? '0 : fill_way + WW'(1);
		end

		new_tags = cur_tags;
		if (is_fill) begin
			new_tags[sel_way] = tag_s1;
		end

		wr = adv && (hit || is_fill);

		hits_d   = hits_q;
		misses_d = misses_q;
		reads_d  = reads_q;
		fills_d  = fills_q;
		case (op_s1)
			OP_READ: begin
				reads_d = (reads_q == '1) ? reads_q : reads_q + 32'd1;
				if (hit) begin
					hits_d = (hits_q == '1) ? hits_q : hits_q + 32'd1;
				end else begin
					misses_d = (misses_q == '1) ? misses_q : misses_q + 32'd1;
				end
			end
			OP_FILL: begin
				fills_d = (fills_q == '1) ? fills_q : fills_q + 32'd1;
			end
			OP_CLEAR: begin
				hits_d   = '0;
				misses_d = '0;
				reads_d  = '0;
				fills_d  = '0;
			end
			default: ;
		endcase

		way_x              = (hit || is_fill) ? {2'b00, sel_way} : '0;
		res.hit            = hit;
		res.way_used       = way_x[1:0];
		res.replaced_valid = is_fill && !inv_found;
		res.hit_count      = hits_d;
		res.miss_count     = misses_d;
		res.access_count   = reads_d;
		res.fill_count     = fills_d;
	end

	// ------------------------------------------------------------ state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q    <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			reads_q      <= '0;
			fills_q      <= '0;
		end else if (adv) begin
			hits_q   <= hits_d;
			misses_q <= misses_d;
			reads_q  <= reads_d;
			fills_q  <= fills_d;
			if (wr) begin
				touched_q[set_s1] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

	// ------------------------------------------------------------ checks
	a_byp_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> valid_s1)
		else $error("bypass flag set with no item in stage 1");

	a_hits_within_reads: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.access_count >= out_data.hit_count))
		else $error("hit count above access count");

	a_hit_not_replace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.replaced_valid))
		else $error("hit and replacement reported together");

	a_write_marks_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> touched_q[$past(set_s1)])
		else $error("written set not marked touched");

endmodule

// ===== src/sacta_ram.sv =====
// ----------------------------------------------------------------------------
// sacta_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module sacta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/sacta_addr_split.sv =====
// ----------------------------------------------------------------------------
// sacta_addr_split
// cuts a byte address into set number and tag under the configured widths
// ----------------------------------------------------------------------------
module sacta_addr_split import sacta_pkg::*; #(
	parameter int SETS      = SETS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	localparam int SW = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  logic [63:0]          address,
	input  cfg_t                 cfg,
	output logic [SW-1:0]        set_num,
	output logic [ADDR_BITS-1:0] tag
);

	logic [63:0]          addr_m;
	logic [3:0]           ow;
	logic [2:0]           iw;
	logic [4:0]           tag_sh;
	logic [63:0]          idx_sh;
	logic [IDX_MAX-1:0]   idx_mask;
	logic [IDX_MAX-1:0]   idx;
	logic [63:0]          tag_full;
	logic [SW-1:0]        set_tab [2**IDX_MAX];

	// constant remainder table, the index is at most six bits
	for (genvar g = 0; g < 2**IDX_MAX; g++) begin : g_tab
		localparam int M = g % SETS;
		assign set_tab[g] = M[SW-1:0];
	end

	always_comb begin
		addr_m   = (ADDR_BITS >= 64) ? address : (address & ((64'd1 << ADDR_BITS) - 64'd1));
		ow       = (cfg.offset_width > 4'(OFS_MAX)) ? 4'(OFS_MAX) : cfg.offset_width;
		iw       = (cfg.index_width > 3'(IDX_MAX)) ? 3'(IDX_MAX) : cfg.index_width;
		tag_sh   = {1'b0, ow} + {2'b0, iw};
		idx_sh   = addr_m >> ow;
		idx_mask = IDX_MAX'((7'd1 << iw) - 7'd1);
		idx      = idx_sh[IDX_MAX-1:0] & idx_mask;
		tag_full = addr_m >> tag_sh;
		set_num  = set_tab[idx];
		tag      = tag_full[ADDR_BITS-1:0];
	end

endmodule

// ===== sim/set_assoc_cache_tag_array_core_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_array_core_tb
// random and directed lookups and fills checked against a behavioral tag array
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_array_core_tb;
	import sacta_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSETS = SETS_DEF;
	localparam int NWAYS = WAYS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	set_assoc_cache_tag_array_core DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	bit [2:0] m_iw;
	bit [3:0] m_ow;
	bit m_rr;
	bit m_valid [NSETS*NWAYS];
	bit [63:0] m_tag [NSETS*NWAYS];
	bit [1:0] m_age [NSETS*NWAYS];
	bit [1:0] m_rr_ptr [NSETS];
	bit [31:0] m_hits, m_misses, m_reads, m_fills;

	in_t beats_to_send [$];
	out_t lookups_due [$];
	int errors = 0;
	int send_idle_pct = 13;
	int recv_idle_pct = 52;
	bit hold_send = 1'b0;
	int quiet_cycles = 0;

	function automatic bit [31:0] sat_inc(bit [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void touch_way(int base, int way);
		bit [1:0] old;
		old = m_age[base+way];
		for (int w = 0; w < NWAYS; w++)
			if (m_age[base+w] < old) m_age[base+w]++;
		m_age[base+way] = '0;
	endfunction

	function automatic void tags_reset();
		m_iw = 6; m_ow = 6; m_rr = 0;
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			m_valid[i] = 0; m_tag[i] = 0; m_age[i] = 2'(i % NWAYS);
		end
		for (int s = 0; s < NSETS; s++) m_rr_ptr[s] = '0;
		m_hits = 0; m_misses = 0; m_reads = 0; m_fills = 0;
	endfunction

	function automatic out_t predict_lookup(in_t b);
		out_t r;
		int iw, ow, set_no, base, way;
		bit [63:0] tag;
		bit found;
		iw = (m_iw > 6) ? 6 : int'(m_iw);
		ow = (m_ow > 12) ? 12 : int'(m_ow);
		set_no = int'(((b.address >> ow) & ((64'd1 << iw) - 64'd1)) % NSETS);
		tag = b.address >> (ow + iw);
		base = set_no * NWAYS;
		r = '0;
		way = 0;
		found = 0;
		case (b.opcode)
			OP_READ: begin
				for (int w = 0; w < NWAYS; w++)
					if (!found && m_valid[base+w] && m_tag[base+w] == tag) begin
						found = 1; way = w;
					end
				if (found) touch_way(base, way);
				m_reads = sat_inc(m_reads);
				if (found) m_hits = sat_inc(m_hits);
				else m_misses = sat_inc(m_misses);
				r.hit = found;
			end
			OP_FILL: begin
				for (int w = 0; w < NWAYS; w++)
					if (!found && !m_valid[base+w]) begin
						found = 1; way = w;
					end
				if (!found) begin
					if (m_rr) begin
						way = m_rr_ptr[set_no];
						m_rr_ptr[set_no] = 2'((way + 1) % NWAYS);
					end else begin
						way = 0;
						for (int w = 1; w < NWAYS; w++)
							if (m_age[base+w] > m_age[base+way]) way = w;
					end
					r.replaced_valid = 1;
				end
				m_tag[base+way] = tag;
				m_valid[base+way] = 1;
				touch_way(base, way);
				m_fills = sat_inc(m_fills);
			end
			OP_CLEAR: begin
				m_hits = 0; m_misses = 0; m_reads = 0; m_fills = 0;
			end
			default: ;
		endcase
		r.way_used = way[1:0];
		r.hit_count = m_hits;
		r.miss_count = m_misses;
		r.access_count = m_reads;
		r.fill_count = m_fills;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				lookups_due.push_back(predict_lookup(in_data));
				beats_to_send.pop_front();
			end
			if ((!in_valid || !in_stall) && !hold_send && beats_to_send.size() > 0
					&& ($urandom_range(99) >= send_idle_pct)) begin
				in_valid <= 1'b1;
				in_data <= (in_valid && !in_stall) ?
					(beats_to_send.size() > 0 ? beats_to_send[0] : in_data) :
					beats_to_send[0];
			end else if (!in_valid || !in_stall) begin
				in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (lookups_due.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					out_t e;
					e = lookups_due.pop_front();
					if (out_data.hit !== e.hit) report_mismatch("hit", out_data.hit, e.hit);
					if (out_data.way_used !== e.way_used)
						report_mismatch("way_used", out_data.way_used, e.way_used);
					if (out_data.replaced_valid !== e.replaced_valid)
						report_mismatch("replaced_valid", out_data.replaced_valid,
							e.replaced_valid);
					if (out_data.hit_count !== e.hit_count)
						report_mismatch("hit_count", out_data.hit_count, e.hit_count);
					if (out_data.miss_count !== e.miss_count)
						report_mismatch("miss_count", out_data.miss_count, e.miss_count);
					if (out_data.access_count !== e.access_count)
						report_mismatch("access_count", out_data.access_count, e.access_count);
					if (out_data.fill_count !== e.fill_count)
						report_mismatch("fill_count", out_data.fill_count, e.fill_count);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic in_t make_beat(bit [1:0] op, bit [63:0] a);
		in_t b;
		b.opcode = op;
		b.address = a;
		return b;
	endfunction

	// address drawn from a small tag and set pool so hits and evictions occur
	function automatic bit [63:0] pool_addr();
		bit [63:0] a;
		if ($urandom_range(9) == 0) return {$urandom, $urandom};
		a = {$urandom, $urandom};
		a[63:20] = (a[63:20] & 44'h3) | ($urandom_range(1) ? 44'hFFF_FFFF_FFFC : 44'h0);
		a[19:14] = a[19:14] & 6'h7;
		return a;
	endfunction

	task automatic drain();
		while (beats_to_send.size() > 0 || lookups_due.size() > 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, bit [3:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_INDEX_WIDTH:  m_iw = val[2:0];
			CFG_OFFSET_WIDTH: m_ow = val;
			default:          m_rr = val[0];
		endcase
	endtask

	task automatic random_phase(int n);
		bit [1:0] op;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: op = OP_CLEAR;
				1: op = 2'd3;
				2, 3, 4, 5, 6, 7, 8: op = OP_FILL;
				default: op = OP_READ;
			endcase
			beats_to_send.push_back(make_beat(op, pool_addr()));
		end
	endtask

	initial begin
		tags_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// directed beats
		beats_to_send.push_back(make_beat(OP_READ, 64'h0));
		beats_to_send.push_back(make_beat(OP_FILL, 64'h0));
		beats_to_send.push_back(make_beat(OP_READ, 64'h0));
		for (int w = 0; w < 5; w++)
			beats_to_send.push_back(make_beat(OP_FILL, {w[15:0], 48'h0}));
		beats_to_send.push_back(make_beat(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF));
		beats_to_send.push_back(make_beat(OP_FILL, 64'hFFFF_FFFF_FFFF_FFFF));
		beats_to_send.push_back(make_beat(OP_READ, 64'hFFFF_FFFF_FFFF_FFFF));
		beats_to_send.push_back(make_beat(2'd3, 64'h1234));
		beats_to_send.push_back(make_beat(OP_CLEAR, 64'h0));
		beats_to_send.push_back(make_beat(OP_READ, 64'h0003_0000_0000_0000));
		drain();
		write_cfg(CFG_REPLACE_MODE, 4'd1);
		write_cfg(CFG_INDEX_WIDTH, 4'd0);
		write_cfg(CFG_OFFSET_WIDTH, 4'd0);
		for (int w = 0; w < 7; w++) beats_to_send.push_back(make_beat(OP_FILL, 64'(w)));
		beats_to_send.push_back(make_beat(OP_READ, 64'd6));
		random_phase(150);
		drain();
		write_cfg(CFG_INDEX_WIDTH, 4'd7);
		write_cfg(CFG_OFFSET_WIDTH, 4'd15);
		random_phase(200);
		// let every pending result come back before continuing
		hold_send = 1'b1;
		while (lookups_due.size() > 0 || in_valid) @(posedge clk);
		hold_send = 1'b0;
		random_phase(100);
		drain();
		send_idle_pct = 52;
		recv_idle_pct = 13;
		write_cfg(CFG_REPLACE_MODE, 4'd0);
		write_cfg(CFG_INDEX_WIDTH, 4'd3);
		write_cfg(CFG_OFFSET_WIDTH, 4'd12);
		random_phase(300);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_cfg(CFG_INDEX_WIDTH, 4'd6);
		write_cfg(CFG_OFFSET_WIDTH, 4'd6);
		write_cfg(CFG_REPLACE_MODE, 4'd1);
		random_phase(330);
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
src/sacta_pkg.sv
src/sacta_ram.sv
src/sacta_addr_split.sv
src/set_assoc_cache_tag_array_core.sv
sim/set_assoc_cache_tag_array_core_tb.sv
